// ----- hw/rtl/vdd_pkg.sv -----
// Shared types and constants for the vector dot/distance unit.
// No dependencies; imported by every module of the block.
package vdd_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int DIFF_WIDTH = ELEM_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   localparam int ACC_WIDTH  = 48;
   localparam int MODE_WIDTH = 2;

   // Highest power of four that fits the accumulator: first trial bit of the root.
   localparam logic [ACC_WIDTH-1:0] ROOT_BIT_INIT = {2'b01, {(ACC_WIDTH-2){1'b0}}};

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_DOT    = 2'd0,
      MODE_SQDIST = 2'd1,
      MODE_DIST   = 2'd2,
      MODE_MAG    = 2'd3
   } vdd_mode_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;    // latch the accepted item and the current mode
      logic mul;        // form the term
      logic acc;        // add the term, saturate, close the vector on last
      logic root_step;  // one digit of the square root
      logic out_load;   // move the finished result into the output register
   } vdd_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic last;       // item in work closes its vector
      logic root_mode;  // item in work asks for a root result
      logic root_done;  // square root has run out of trial bits
      logic out_free;   // output register can take a result this cycle
   } vdd_status_type;

endpackage

// ----- hw/rtl/vdd_ctrl.sv -----
// Controller state machine of the vector dot/distance unit.
// Depends on vdd_pkg; drives commands to vdd_dpath and the input stall.
module vdd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  vdd_pkg::vdd_status_type status,
   output vdd_pkg::vdd_cmd_type    cmd
);
   import vdd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ACC  = 5'b00100,
      S_ROOT = 5'b01000,
      S_OUT  = 5'b10000
   } vdd_state_type;

   vdd_state_type state_ff;
   vdd_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            priority if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.root_mode) begin
               state_in = S_ROOT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_ROOT: begin
            if (status.root_done) begin
               state_in = S_OUT;
            end else begin
               cmd.root_step = 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/vdd_dpath.sv -----
// Datapath of the vector dot/distance unit: term multiplier, saturating
// accumulator, bit-serial square root and output register. Depends on vdd_pkg.
module vdd_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vdd_pkg::MODE_WIDTH-1:0]        csr_metric_mode,
   input  logic signed [vdd_pkg::ELEM_WIDTH-1:0] req_elem_a,
   input  logic signed [vdd_pkg::ELEM_WIDTH-1:0] req_elem_b,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vdd_pkg::ACC_WIDTH-1:0]  rsp_result,
   output logic                                  rsp_saturated,
   input  vdd_pkg::vdd_cmd_type                  cmd,
   output vdd_pkg::vdd_status_type               status
);
   import vdd_pkg::*;

   vdd_mode_type                 cfg_mode_ff;
   vdd_mode_type                 mode_ff;
   logic signed [ELEM_WIDTH-1:0] a_ff;
   logic signed [ELEM_WIDTH-1:0] b_ff;
   logic                         last_ff;
   logic signed [PROD_WIDTH-1:0] term_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic                         clamp_ff;
   logic signed [ACC_WIDTH-1:0]  fin_ff;
   logic                         fin_sat_ff;
   logic [ACC_WIDTH-1:0]         rad_ff;
   logic [ACC_WIDTH-1:0]         root_ff;
   logic [ACC_WIDTH-1:0]         bit_ff;
   logic                         rsp_valid_ff;
   logic signed [ACC_WIDTH-1:0]  rsp_result_ff;
   logic                         rsp_sat_ff;

   logic signed [DIFF_WIDTH-1:0] op_x;
   logic signed [DIFF_WIDTH-1:0] op_y;
   logic signed [DIFF_WIDTH-1:0] diff;
   logic signed [PROD_WIDTH-1:0] term_in;
   logic signed [ACC_WIDTH:0]    sum_wide;
   logic signed [ACC_WIDTH-1:0]  sum_sat;
   logic                         sum_ovf;
   logic [ACC_WIDTH-1:0]         trial;
   logic                         trial_fits;
   logic                         is_root_mode;

   assign csr_ready = 1'b1;

   // Term select: a*b, a*a, or the squared difference.
   always_comb begin
      diff = DIFF_WIDTH'(a_ff) - DIFF_WIDTH'(b_ff);
      unique case (mode_ff)
         MODE_DOT: begin
            op_x = DIFF_WIDTH'(a_ff);
            op_y = DIFF_WIDTH'(b_ff);
         end
         MODE_MAG: begin
            op_x = DIFF_WIDTH'(a_ff);
            op_y = DIFF_WIDTH'(a_ff);
         end
         default: begin
            op_x = diff;
            op_y = diff;
         end
      endcase
      term_in = op_x * op_y;
   end

   // Saturating accumulate.
   always_comb begin
      sum_wide = (ACC_WIDTH+1)'(acc_ff) + (ACC_WIDTH+1)'(term_ff);
      sum_ovf  = sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1];
      if (!sum_ovf) begin
         sum_sat = sum_wide[ACC_WIDTH-1:0];
      end else if (sum_wide[ACC_WIDTH]) begin
         sum_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
   end

   assign trial        = root_ff + bit_ff;
   assign trial_fits   = rad_ff >= trial;
   assign is_root_mode = (mode_ff == MODE_DIST) || (mode_ff == MODE_MAG);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff    <= req_elem_a;
         b_ff    <= req_elem_b;
         last_ff <= req_last;
      end
      if (cmd.mul) begin
         term_ff <= term_in;
      end
      if (cmd.acc && last_ff) begin
         fin_ff     <= sum_sat;
         fin_sat_ff <= clamp_ff | sum_ovf;
         rad_ff     <= sum_sat[ACC_WIDTH-1] ? '0 : sum_sat;
         root_ff    <= '0;
      end else if (cmd.root_step) begin
         if (trial_fits) begin
            rad_ff  <= rad_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
      if (cmd.out_load) begin
         rsp_result_ff <= is_root_mode ? root_ff : fin_ff;
         rsp_sat_ff    <= fin_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff  <= MODE_DOT;
         mode_ff      <= MODE_DOT;
         acc_ff       <= '0;
         clamp_ff     <= 1'b0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_mode_ff <= vdd_mode_type'(csr_metric_mode);
         end
         if (cmd.capture) begin
            mode_ff <= cfg_mode_ff;
         end
         if (cmd.acc) begin
            if (last_ff) begin
               acc_ff   <= '0;
               clamp_ff <= 1'b0;
               bit_ff   <= ROOT_BIT_INIT;
            end else begin
               acc_ff   <= sum_sat;
               clamp_ff <= clamp_ff | sum_ovf;
            end
         end else if (cmd.root_step) begin
            bit_ff <= bit_ff >> 2;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.last      = last_ff;
   assign status.root_mode = is_root_mode;
   assign status.root_done = (bit_ff == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_result_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && last_ff) |=> (acc_ff == '0 && !clamp_ff))
      else $error("accumulator not cleared after the closing item");

   a_root_bit_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bit_ff))
      else $error("square root trial bit lost its single-bit form");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register loaded over a stalled result");

   a_step_needs_bit: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> (bit_ff != '0))
      else $error("square root stepped past its last digit");

endmodule

// ----- hw/rtl/vector_dot_distance_unit.sv -----
// Top level of the vector dot/distance unit.
// Depends on vdd_pkg, vdd_ctrl and vdd_dpath.
//
// Usage:
//   req_* carries one element pair (signed Q8.8 elem_a, elem_b) per item,
//   with req_last marking the final pair of a vector. rsp_* carries one item
//   per vector: rsp_result (Q16.16 sum in dot and squared-distance modes,
//   floor square root in Q8.8 in distance and magnitude modes) and
//   rsp_saturated, set when the 48-bit accumulator clamped in that vector.
//   csr_* writes the 2-bit metric mode; csr_ready is always high. Write the
//   mode only while the unit is idle. Each item uses the mode held when it
//   was accepted.
// Sequence:
//   A non-final pair passes through accept, multiply and accumulate, and the
//   input takes no new pair until it is through. A final pair in a sum mode
//   then moves its result into the output register; in a root mode the
//   bit-serial square root runs first, one result bit per cycle over 24 bits.
//   A final pair holds the input until its result is loaded: the next pair
//   waits for the square root in a root mode and for a free output register.
//   The unit has a single multiplier and a bit-serial square-root unit.
// Reset and stall:
//   Synchronous reset clears the mode to dot product, the accumulator, the
//   clamp flag and the output valid flag. A stalled result holds in the
//   output register; the unit then accepts and accumulates further pairs
//   and waits only when the next vector's result is ready to go out.
module vector_dot_distance_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vdd_pkg::MODE_WIDTH-1:0]        csr_metric_mode,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [vdd_pkg::ELEM_WIDTH-1:0] req_elem_a,
   input  logic signed [vdd_pkg::ELEM_WIDTH-1:0] req_elem_b,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vdd_pkg::ACC_WIDTH-1:0]  rsp_result,
   output logic                                  rsp_saturated
);
   import vdd_pkg::*;

   // Command and status between the sequencer and the datapath.
   vdd_cmd_type    cmd;
   vdd_status_type status;

   // Sequence each item: accept, multiply, accumulate, then on the final pair
   // the square root (in a root mode only) and the output.
   vdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the mode register, the multiplier, the accumulator, the root unit and the output.
   vdd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_metric_mode (csr_metric_mode),
      .req_elem_a      (req_elem_a),
      .req_elem_b      (req_elem_b),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_saturated   (rsp_saturated),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for vector_dot_distance_unit.
// Holds its own predictor and a scoreboard class; depends on vdd_pkg and the
// RTL of the block only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vdd_pkg::*;

   // 48-bit signed accumulator limits, held in 64-bit arithmetic
   localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -ACC_HI - 1;

   // Slowest correct run: about 1650 pairs, each of which may see the longest
   // gap, its work, the root, the longest receiver stall and a mode change that
   // waits out SETTLE_CYCLES. That stays well under CYCLE_LIMIT.
   localparam longint CYCLE_LIMIT = 2_000_000;

   // Cycles to let pass once nothing is expected: covers a non-final pair
   // still in the pipeline and the bit-serial root.
   localparam int SETTLE_CYCLES = 40;

   localparam int RANDOM_PAIRS = 1600;

   typedef struct {
      logic signed [ACC_WIDTH-1:0] result;
      logic                        saturated;
   } vector_metric_type;

   // Tracks the mode and accumulator of the block and the metrics still owed.
   class metric_scoreboard_type;
      vdd_mode_type      mode;
      longint            running_total;
      bit                clamp_hit;
      vector_metric_type expected_metrics[$];
      int                errors;

      function new();
         mode          = MODE_DOT;
         running_total = 0;
         clamp_hit     = 1'b0;
         errors        = 0;
      endfunction

      // Floor square root, one result bit at a time from the top.
      function longint floor_root(longint x);
         longint root;
         longint trial;
         root = 0;
         for (int i = 23; i >= 0; i--) begin
            trial = root | (64'sd1 << i);
            if (trial * trial <= x) root = trial;
         end
         return root;
      endfunction

      // Add one accepted pair; on the last pair of a vector queue its metric.
      function void accumulate_pair(logic signed [ELEM_WIDTH-1:0] a,
                                    logic signed [ELEM_WIDTH-1:0] b,
                                    logic                         last);
         longint            ea;
         longint            eb;
         longint            term;
         longint            total;
         vector_metric_type metric;
         ea = a;
         eb = b;
         case (mode)
            MODE_DOT: term = ea * eb;
            MODE_MAG: term = ea * ea;
            default:  term = (ea - eb) * (ea - eb);
         endcase
         total = running_total + term;
         if (total > ACC_HI) begin
            total     = ACC_HI;
            clamp_hit = 1'b1;
         end else if (total < ACC_LO) begin
            total     = ACC_LO;
            clamp_hit = 1'b1;
         end
         running_total = total;
         if (last) begin
            if (mode == MODE_DIST || mode == MODE_MAG) begin
               metric.result = (running_total < 0) ? '0
                                                   : ACC_WIDTH'(floor_root(running_total));
            end else begin
               metric.result = running_total[ACC_WIDTH-1:0];
            end
            metric.saturated = clamp_hit;
            expected_metrics.push_back(metric);
            running_total = 0;
            clamp_hit     = 1'b0;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      // Compare one accepted result with the oldest metric owed.
      task check_result(logic signed [ACC_WIDTH-1:0] result, logic saturated);
         vector_metric_type metric;
         if (expected_metrics.size() == 0) begin
            report($sformatf("result %0d arrived with no vector closed", result));
            return;
         end
         metric = expected_metrics.pop_front();
         if (result !== metric.result) begin
            report($sformatf("result %0d, expected %0d", result, metric.result));
         end
         if (saturated !== metric.saturated) begin
            report($sformatf("saturated %0b, expected %0b (result %0d)",
                             saturated, metric.saturated, metric.result));
         end
      endtask

      function int pending();
         return expected_metrics.size();
      endfunction
   endclass

   // Drive every input to a known value from time zero.
   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         csr_valid       = 1'b0;
   logic                         csr_ready;
   logic [MODE_WIDTH-1:0]        csr_metric_mode = MODE_DOT;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic signed [ELEM_WIDTH-1:0] req_elem_a      = '0;
   logic signed [ELEM_WIDTH-1:0] req_elem_b      = '0;
   logic                         req_last        = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic signed [ACC_WIDTH-1:0]  rsp_result;
   logic                         rsp_saturated;

   metric_scoreboard_type metrics = new();
   longint                cycle_count = 0;
   int                    stall_run = 0;

   vector_dot_distance_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_metric_mode (csr_metric_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elem_a      (req_elem_a),
      .req_elem_b      (req_elem_b),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_saturated   (rsp_saturated)
   );

   always #2 clock = ~clock;

   // Idle lengths: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Element values: full range, the extremes around zero and the limits,
   // and small magnitudes that keep sums readable.
   function automatic logic signed [ELEM_WIDTH-1:0] pick_elem();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return ELEM_WIDTH'($urandom_range(0, 65535));
      if (r < 65) begin
         case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return -16'sd1;
            3:       return 16'sd1;
            default: return 16'sd0;
         endcase
      end
      return ELEM_WIDTH'($urandom_range(0, 2047) - 1024);
   endfunction

   // Vector lengths: mostly short, some medium, a few long.
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 30);
      return $urandom_range(31, 120);
   endfunction

   // Receiver: alternate stalled and free runs; now and then a long free
   // stretch so results also drain back to back.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         if (rsp_stall) begin
            rsp_stall <= 1'b0;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 8);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = pick_gap();
         end
      end else begin
         stall_run--;
      end
   end

   // Check every accepted result against the oldest metric owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         metrics.check_result(rsp_result, rsp_saturated);
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         metrics.report($sformatf("timeout after %0d cycles, %0d metrics still owed",
                                  cycle_count, metrics.pending()));
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one pair, hold it until accepted, then note it in the predictor.
   // Enter and leave at a falling edge; valid stays high when no gap follows.
   task automatic push_pair(int a, int b, bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_elem_a <= a[ELEM_WIDTH-1:0];
      req_elem_b <= b[ELEM_WIDTH-1:0];
      req_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      metrics.accumulate_pair(req_elem_a, req_elem_b, req_last);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed metric and for the pipeline to empty,
   // then write the mode. Also used inside an open vector.
   task automatic change_mode(vdd_mode_type mode);
      req_valid <= 1'b0;
      while (metrics.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_metric_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      metrics.mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int len;

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: dot product at the product extremes and a short vector.
      change_mode(MODE_DOT);
      push_pair(32767, 32767, 1);
      push_pair(-32768, -32768, 1);
      push_pair(-32768, 32767, 1);
      push_pair(0, 0, 1);
      push_pair(1, -1, 0);
      push_pair(256, 256, 1);

      // Squared distance at the largest difference both ways.
      change_mode(MODE_SQDIST);
      push_pair(32767, -32768, 1);
      push_pair(-32768, 32767, 1);
      push_pair(-1, 0, 1);

      // Distance: root of the largest square and of a two-pair vector.
      change_mode(MODE_DIST);
      push_pair(32767, -32768, 1);
      push_pair(3, 1, 0);
      push_pair(100, 0, 1);

      // Magnitude: elem_b must not matter.
      change_mode(MODE_MAG);
      push_pair(-32768, 12345, 1);
      push_pair(5, -7, 1);

      // Mode change inside a vector: a negative dot sum closed in a root mode
      // must give zero.
      change_mode(MODE_DOT);
      push_pair(-32768, 32767, 0);
      change_mode(MODE_DIST);
      push_pair(0, 0, 1);

      // Root-mode terms closed in a sum mode give the plain sum.
      change_mode(MODE_MAG);
      push_pair(1000, 0, 0);
      change_mode(MODE_SQDIST);
      push_pair(1, 3, 1);

      // Random vectors with random content; the mode changes between vectors
      // and now and then inside one.
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         if ($urandom_range(0, 4) == 0) change_mode(vdd_mode_type'($urandom_range(0, 3)));
         len = pick_length();
         for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 59) == 0) begin
               change_mode(vdd_mode_type'($urandom_range(0, 3)));
            end
            push_pair(pick_elem(), pick_elem(), k == len - 1);
            sent++;
         end
      end

      // Drain: wait for every owed metric, then give stray results a chance.
      req_valid <= 1'b0;
      while (metrics.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (metrics.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
